@@ rtl/twhl_pkg.sv @@
// ----------------------------------------------------------------------------
// twhl_pkg
// Shared types and constants for the two-wire handshake link transceiver.
// ----------------------------------------------------------------------------
package twhl_pkg;

  // command codes carried on the opcode field
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2,
    OP_PROBE = 2'd3
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_SETTLE  = 2'd1,
    CFG_RSVD2   = 2'd2,
    CFG_RSVD3   = 2'd3
  } cfg_idx_e;

  localparam int unsigned TimeoutW = 24;
  localparam int unsigned SettleW  = 16;
  localparam int unsigned CfgDataW = 24;

  localparam logic [TimeoutW-1:0] TimeoutRst = 24'd1000000;
  localparam logic [SettleW-1:0]  SettleRst  = 16'd10;

  // one result word
  typedef struct packed {
    logic       red_pull_low;
    logic       white_pull_low;
    logic       busy;
    logic       done;
    logic       err;
    logic [7:0] rx_byte;
    logic       line_activity;
  } result_t;

endpackage

@@ rtl/twhl_core.sv @@
// ----------------------------------------------------------------------------
// twhl_core
// Link state machine: one tick of line samples per fire, result in same cycle.
// ----------------------------------------------------------------------------
module twhl_core
  import twhl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                red_level_i,
  input  logic                white_level_i,
  input  logic [TimeoutW-1:0] timeout_i,
  input  logic [SettleW-1:0]  settle_i,
  output result_t             res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TX_WAIT_LOW,
    PH_TX_WAIT_HIGH,
    PH_RX_WAIT_ANY,
    PH_RX_WAIT_RELEASE,
    PH_RX_SETTLE,
    PH_PROBE_WAIT
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [2:0]          bit_cnt_q, bit_cnt_d;
  logic [7:0]          shift_q, shift_d;
  logic                cur_bit_q, cur_bit_d;
  logic [TimeoutW-1:0] wait_cnt_q, wait_cnt_d;
  logic [SettleW-1:0]  settle_cnt_q, settle_cnt_d;
  logic                red_drv_q, red_drv_d;
  logic                white_drv_q, white_drv_d;

  logic [TimeoutW-1:0] wait_inc;
  logic [SettleW-1:0]  settle_inc;
  logic                expired;
  logic                tx_watch_hi, rx_watch_hi;
  logic [7:0]          shift_nx;
  logic                done, err, bit_done;
  logic [7:0]          rxb;

  assign wait_inc    = wait_cnt_q + TimeoutW'(1);
  assign settle_inc  = settle_cnt_q + SettleW'(1);
  assign expired     = (wait_inc >= timeout_i);
  assign tx_watch_hi = cur_bit_q ? red_level_i : white_level_i;
  assign rx_watch_hi = cur_bit_q ? white_level_i : red_level_i;
  assign shift_nx    = {1'b0, shift_q[7:1]};

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    cur_bit_d    = cur_bit_q;
    wait_cnt_d   = wait_cnt_q;
    settle_cnt_d = settle_cnt_q;
    red_drv_d    = red_drv_q;
    white_drv_d  = white_drv_q;
    done         = 1'b0;
    err          = 1'b0;
    bit_done     = 1'b0;
    rxb          = 8'd0;

    case (phase_q)
      PH_IDLE: begin
        case (opcode_i)
          OP_SEND: begin
            bit_cnt_d  = 3'd0;
            shift_d    = tx_byte_i;
            cur_bit_d  = tx_byte_i[0];
            if (tx_byte_i[0]) begin
              white_drv_d = 1'b1;
            end else begin
              red_drv_d = 1'b1;
            end
            wait_cnt_d = '0;
            phase_d    = PH_TX_WAIT_LOW;
          end
          OP_RECV: begin
            bit_cnt_d  = 3'd0;
            shift_d    = 8'd0;
            wait_cnt_d = '0;
            phase_d    = PH_RX_WAIT_ANY;
          end
          OP_PROBE: begin
            red_drv_d   = 1'b0;
            white_drv_d = 1'b0;
            wait_cnt_d  = '0;
            phase_d     = PH_PROBE_WAIT;
          end
          default: ;
        endcase
      end
      PH_TX_WAIT_LOW: begin
        if (!tx_watch_hi) begin
          red_drv_d   = 1'b0;
          white_drv_d = 1'b0;
          wait_cnt_d  = '0;
          phase_d     = PH_TX_WAIT_HIGH;
        end else begin
          wait_cnt_d = wait_inc;
          err        = expired;
        end
      end
      PH_TX_WAIT_HIGH: begin
        if (tx_watch_hi) begin
          if (bit_cnt_q == 3'd7) begin
            done = 1'b1;
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
            shift_d   = shift_nx;
            cur_bit_d = shift_nx[0];
            if (shift_nx[0]) begin
              white_drv_d = 1'b1;
            end else begin
              red_drv_d = 1'b1;
            end
            wait_cnt_d = '0;
            phase_d    = PH_TX_WAIT_LOW;
          end
        end else begin
          wait_cnt_d = wait_inc;
          err        = expired;
        end
      end
      PH_RX_WAIT_ANY: begin
        if (!(red_level_i && white_level_i)) begin
          // only white low means a one
          cur_bit_d = red_level_i && !white_level_i;
          shift_d   = {red_level_i && !white_level_i, shift_q[7:1]};
          if (red_level_i && !white_level_i) begin
            red_drv_d = 1'b1;
          end else begin
            white_drv_d = 1'b1;
          end
          wait_cnt_d = '0;
          phase_d    = PH_RX_WAIT_RELEASE;
        end else begin
          wait_cnt_d = wait_inc;
          err        = expired;
        end
      end
      PH_RX_WAIT_RELEASE: begin
        if (rx_watch_hi) begin
          red_drv_d   = 1'b0;
          white_drv_d = 1'b0;
          if (settle_i == '0) begin
            bit_done = 1'b1;
          end else begin
            settle_cnt_d = '0;
            phase_d      = PH_RX_SETTLE;
          end
        end else begin
          wait_cnt_d = wait_inc;
          err        = expired;
        end
      end
      PH_RX_SETTLE: begin
        settle_cnt_d = settle_inc;
        bit_done     = (settle_inc >= settle_i);
      end
      PH_PROBE_WAIT: begin
        if (red_level_i && white_level_i) begin
          done = 1'b1;
        end else begin
          wait_cnt_d = wait_inc;
          err        = expired;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (bit_done) begin
      if (bit_cnt_q == 3'd7) begin
        done = 1'b1;
        rxb  = shift_d;
      end else begin
        bit_cnt_d  = bit_cnt_q + 3'd1;
        wait_cnt_d = '0;
        phase_d    = PH_RX_WAIT_ANY;
      end
    end
    if (err) begin
      done        = 1'b1;
      red_drv_d   = 1'b0;
      white_drv_d = 1'b0;
    end
    if (done) begin
      phase_d      = PH_IDLE;
      wait_cnt_d   = '0;
      settle_cnt_d = '0;
    end

    res_o.red_pull_low   = red_drv_d;
    res_o.white_pull_low = white_drv_d;
    res_o.busy           = (phase_d != PH_IDLE);
    res_o.done           = done;
    res_o.err            = err;
    res_o.rx_byte        = err ? 8'd0 : rxb;
    res_o.line_activity  = !(red_level_i && white_level_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      cur_bit_q    <= 1'b0;
      wait_cnt_q   <= '0;
      settle_cnt_q <= '0;
      red_drv_q    <= 1'b0;
      white_drv_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      cur_bit_q    <= cur_bit_d;
      wait_cnt_q   <= wait_cnt_d;
      settle_cnt_q <= settle_cnt_d;
      red_drv_q    <= red_drv_d;
      white_drv_q  <= white_drv_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(red_drv_q && white_drv_q))
    else $error("both lines pulled low at once");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!red_drv_q && !white_drv_q && wait_cnt_q == '0))
    else $error("idle with a line driven or wait count left");

  a_err_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.err) |=> (phase_q == PH_IDLE && !red_drv_q && !white_drv_q))
    else $error("timeout did not release lines and return to idle");

  a_settle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RX_SETTLE) |-> (!red_drv_q && !white_drv_q))
    else $error("line still pulled low while settling");
`endif

endmodule

@@ rtl/two_wire_handshake_link_transceiver_top.sv @@
// ----------------------------------------------------------------------------
// two_wire_handshake_link_transceiver_top
// Two-wire open-drain handshake link controller, one line sample per word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ---------------------------------------
//  in       in   in_valid_i/in_ready_o  opcode, tx_byte, red_level, white_level
//  out      out  out_valid_o/out_ready_i red/white_pull_low, busy, done, error,
//                                        rx_byte, line_activity
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One word per cycle sustained while the result is drained; a word passes the
//  input register, then the state step and the result register.
//  The state step is a single pass through twhl_core; state advances only
//  when an input word moves into the result register.
//  Reset: async active low; link idle, both lines released, timeout 1000000,
//  settle 10.
//  A stalled result holds the state step; the input register still takes one
//  word while the result waits, then in_ready_o drops.
//  Config writes are always taken (cfg_ready_o is high); index 2 and 3 ignored.
// ----------------------------------------------------------------------------
module two_wire_handshake_link_transceiver_top
  import twhl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                red_level_i,
  input  logic                white_level_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                red_pull_low_o,
  output logic                white_pull_low_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic                error_code_o,
  output logic [7:0]          rx_byte_o,
  output logic                line_activity_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // config registers
  logic [TimeoutW-1:0] timeout_q;
  logic [SettleW-1:0]  settle_q;

  // input register
  logic       in_vld_q;
  logic [1:0] opcode_q;
  logic [7:0] tx_byte_q;
  logic       red_q, white_q;

  // result register
  logic    out_vld_q;
  result_t res_q;
  result_t res;

  logic step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      settle_q  <= SettleRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[TimeoutW-1:0];
        CFG_SETTLE:  settle_q  <= cfg_data_i[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // a word steps the link when the result slot is free or being drained
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      opcode_q  <= opcode_i;
      tx_byte_q <= tx_byte_i;
      red_q     <= red_level_i;
      white_q   <= white_level_i;
    end
  end

  twhl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (step),
    .opcode_i      (opcode_q),
    .tx_byte_i     (tx_byte_q),
    .red_level_i   (red_q),
    .white_level_i (white_q),
    .timeout_i     (timeout_q),
    .settle_i      (settle_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign red_pull_low_o   = res_q.red_pull_low;
  assign white_pull_low_o = res_q.white_pull_low;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign error_code_o     = res_q.err;
  assign rx_byte_o        = res_q.rx_byte;
  assign line_activity_o  = res_q.line_activity;

`ifndef NO_ASSERTIONS
  a_step_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (!out_vld_q || out_ready_i))
    else $error("result overwritten while stalled");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.done |=> out_vld_q && !busy_res_o)
    else $error("finished operation still reports busy");

  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && error_code_o |-> done_res_o && rx_byte_o == 8'd0)
    else $error("error flagged without done or with data");
`endif

endmodule
